// File: rtl/dbss_pkg.sv
// Package for the disk buffer sector sequencer: beat structs, slot constants,
// zone tables and register map. No dependencies.
package dbss_pkg;

   // Sector slot layout of one 90-slot block
   localparam logic [7:0] SLOTS_PER_BLOCK = 8'h5A;
   localparam logic [7:0] USER_SLOTS      = 8'h55;
   localparam logic [7:0] LAST_C2_SLOT    = 8'h58;
   localparam logic [7:0] WRITE_STOP_SLOT = 8'h56;

   // Copy-protection flags fire on head 0, track 6
   localparam logic [12:0] C1_TRACK = 13'd6;

   // Action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // Transfer kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // Widths
   localparam int OFS_W      = 27;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map (word index = paddr[2])
   localparam logic REG_SECTOR_BYTES = 1'b0;

   typedef struct packed {
      logic        action;
      logic        read_mode;
      logic        block_transfer;
      logic [12:0] track;
      logic [7:0]  sector;
   } req_type;

   typedef struct packed {
      logic             irq_raised;
      logic             user_request;
      logic             c2_request;
      logic             c1_single;
      logic             c1_double;
      logic [1:0]       transfer_kind;
      logic [OFS_W-1:0] disk_offset;
      logic             busy_res;
      logic [7:0]       next_sector;
   } rsp_type;

   // Job handed to the offset unit
   typedef struct packed {
      logic [7:0]  sector;
      logic [12:0] track_head;
      logic [7:0]  bytes_m1;
   } ofs_req_type;

   // First track of each zone
   function automatic logic [11:0] zone_bound(input logic [2:0] zone);
      logic [11:0] b;
      unique case (zone)
         3'd0:    b = 12'h000;
         3'd1:    b = 12'h09E;
         3'd2:    b = 12'h13C;
         3'd3:    b = 12'h1D1;
         3'd4:    b = 12'h266;
         3'd5:    b = 12'h2FB;
         3'd6:    b = 12'h390;
         default: b = 12'h425;
      endcase
      return b;
   endfunction

   // Byte offset of each zone's first track, indexed {head, zone}
   function automatic logic [OFS_W-1:0] zone_start(input logic [3:0] idx);
      logic [OFS_W-1:0] s;
      unique case (idx)
         4'd0:    s = 27'h0000000;
         4'd1:    s = 27'h05F15E0;
         4'd2:    s = 27'h0B79D00;
         4'd3:    s = 27'h10801A0;
         4'd4:    s = 27'h1523720;
         4'd5:    s = 27'h1963D80;
         4'd6:    s = 27'h1D414C0;
         4'd7:    s = 27'h20BBCE0;
         4'd8:    s = 27'h23196E0;
         4'd9:    s = 27'h28A1E00;
         4'd10:   s = 27'h2DF5DC0;
         4'd11:   s = 27'h3299340;
         4'd12:   s = 27'h36D99A0;
         4'd13:   s = 27'h3AB70E0;
         4'd14:   s = 27'h3E31900;
         default: s = 27'h4149200;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/dbss_offset_unit.sv
// Zoned byte offset unit: zone lookup, then a shift-add multiply and final
// zone-start add through one shared 27-bit adder. Depends on dbss_pkg.
module dbss_offset_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  dbss_pkg::ofs_req_type     ofs_req,
   output logic                      done,
   output logic [dbss_pkg::OFS_W-1:0] offset
);
   import dbss_pkg::*;

   localparam int         MUL_STEPS = 9;
   localparam logic [3:0] MUL_LAST  = 4'(MUL_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ZONE, ST_SCALE, ST_MUL, ST_ADD
   } state_type;

   state_type        state_ff, state_in;
   logic             done_ff, done_in;
   logic             blk_ff;
   logic [6:0]       slot_ff;
   logic [11:0]      trk_ff;
   logic             head_ff;
   logic [8:0]       mult_ff, mult_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [2:0]       zone_ff;
   logic [11:0]      dt_ff;
   logic [OFS_W-1:0] mcand_ff, mcand_in;
   logic [OFS_W-1:0] acc_ff, acc_in;

   logic [7:0]       start_slot;
   logic [2:0]       zone_cnt;
   logic [OFS_W-1:0] addend;
   logic [OFS_W-1:0] sum;
   logic [OFS_W-1:0] scaled;

   // Slot within block for the incoming sector
   assign start_slot = (ofs_req.sector >= SLOTS_PER_BLOCK) ?
                       ofs_req.sector - SLOTS_PER_BLOCK : ofs_req.sector;

   // Zone = number of zone bounds above zone 0 that are at or below the track
   always_comb begin
      zone_cnt = '0;
      for (int k = 1; k < 8; k++) begin
         if (trk_ff >= zone_bound(3'(k))) begin
            zone_cnt = zone_cnt + 3'd1;
         end
      end
   end

   // 170*dt + 85*blk + slot
   assign scaled = (OFS_W'(dt_ff) << 7) + (OFS_W'(dt_ff) << 5) + (OFS_W'(dt_ff) << 3)
                 + (OFS_W'(dt_ff) << 1) + (blk_ff ? OFS_W'(USER_SLOTS) : '0)
                 + OFS_W'(slot_ff);

   // Shared adder
   assign addend = (state_ff == ST_ADD) ? zone_start({head_ff, zone_ff}) :
                   (mult_ff[0] ? mcand_ff : '0);
   assign sum    = acc_ff + addend;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      mult_in  = mult_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ZONE;
               mult_in  = 9'(ofs_req.bytes_m1) + 9'd1;
            end
         end
         ST_ZONE: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_MUL;
            mcand_in = scaled;
            acc_in   = '0;
            cnt_in   = '0;
         end
         ST_MUL: begin
            acc_in   = sum;
            mcand_in = mcand_ff << 1;
            mult_in  = mult_ff >> 1;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            acc_in   = sum;
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mult_ff  <= mult_in;
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      if (state_ff == ST_IDLE && start) begin
         blk_ff  <= ofs_req.sector >= SLOTS_PER_BLOCK;
         slot_ff <= start_slot[6:0];
         trk_ff  <= ofs_req.track_head[11:0];
         head_ff <= ofs_req.track_head[12];
      end
      if (state_ff == ST_ZONE) begin
         zone_ff <= zone_cnt;
         dt_ff   <= trk_ff - zone_bound(zone_cnt);
      end
   end

   assign done   = done_ff;
   assign offset = acc_ff;

endmodule

// File: rtl/disk_buffer_sector_sequencer.sv
// Disk buffer sector sequencer: item handshake, sequencing state, register
// port and result register. Depends on dbss_pkg and dbss_offset_unit.
//
// For a start item or a tick that moves no sector, the result goes from the
// step decision through the emit state into the result register. For a tick
// that moves a sector, the offset unit runs first (start, zone lookup, scale,
// 9 shift-add steps over the sector size, zone-start add) on one shared
// adder, and its offset is handed over before the result register loads.
// A stalled result beat holds the next result in the emit state. One item
// is in work at a time; req_ready is high while the sequencer is idle, also
// while a result waits.
module disk_buffer_sector_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dbss_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dbss_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dbss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dbss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dbss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import dbss_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_type;

   state_type   state_ff, state_in;
   logic        running_ff, running_in;
   logic        mode_ff, mode_in;
   logic        wrap_ff, wrap_in;
   logic [7:0]  sector_ff, sector_in;
   logic [12:0] track_ff, track_in;
   logic [7:0]  sbm1_ff;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        accept;
   logic        load_rsp;
   logic        cur_blk;
   logic [7:0]  cur_slot;
   logic [7:0]  wrap_target;
   logic [7:0]  sec_work;
   logic        need_ofs;
   logic [7:0]  ofs_sec;
   ofs_req_type ofs_req;
   logic        ofs_done;
   logic [OFS_W-1:0] ofs_value;
   logic        csr_write;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign load_rsp  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Position of the current sector
   assign cur_blk     = sector_ff >= SLOTS_PER_BLOCK;
   assign cur_slot    = cur_blk ? sector_ff - SLOTS_PER_BLOCK : sector_ff;
   assign wrap_target = cur_blk ? 8'd0 : SLOTS_PER_BLOCK;

   // Step decision for the accepted beat
   always_comb begin
      running_in = running_ff;
      mode_in    = mode_ff;
      wrap_in    = wrap_ff;
      sector_in  = sector_ff;
      track_in   = track_ff;
      res_in     = res_ff;
      need_ofs   = 1'b0;
      ofs_sec    = sector_ff;
      sec_work   = sector_ff;
      if (accept) begin
         res_in = '0;
         if (req_payload.action == ACT_START) begin
            running_in = 1'b1;
            mode_in    = req_payload.read_mode;
            wrap_in    = req_payload.block_transfer;
            track_in   = req_payload.track;
            sector_in  = req_payload.sector;
         end else if (running_ff) begin
            res_in.irq_raised = 1'b1;
            if (mode_ff) begin
               res_in.c1_single = (track_ff == C1_TRACK);
               res_in.c1_double = (track_ff == C1_TRACK);
               if (cur_slot < USER_SLOTS) begin
                  need_ofs                = 1'b1;
                  res_in.transfer_kind    = KIND_READ;
                  res_in.user_request     = 1'b1;
                  sec_work                = sector_ff + 8'd1;
               end else if (cur_slot < LAST_C2_SLOT) begin
                  sec_work = sector_ff + 8'd1;
               end else if (cur_slot == LAST_C2_SLOT) begin
                  res_in.c2_request = 1'b1;
                  if (wrap_ff) begin
                     wrap_in  = 1'b0;
                     sec_work = wrap_target;
                  end else begin
                     running_in = 1'b0;
                  end
               end
            end else begin
               if (cur_slot <= USER_SLOTS) begin
                  // slot 0 of a write only raises the request
                  if (cur_slot != 8'd0) begin
                     need_ofs             = 1'b1;
                     ofs_sec              = sector_ff - 8'd1;
                     res_in.transfer_kind = KIND_WRITE;
                  end
                  res_in.user_request = 1'b1;
               end
               if (cur_slot >= USER_SLOTS) begin
                  if (wrap_ff) begin
                     wrap_in  = 1'b0;
                     sec_work = wrap_target;
                  end else if (cur_slot >= WRITE_STOP_SLOT) begin
                     running_in = 1'b0;
                  end
               end
               sec_work = sec_work + 8'd1;
            end
            sector_in = sec_work;
         end
         res_in.busy_res    = running_in;
         res_in.next_sector = sector_in;
      end else if (state_ff == ST_CALC && ofs_done) begin
         res_in.disk_offset = ofs_value;
      end
   end

   // Sequencer state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_ofs ? ST_CALC : ST_EMIT;
            end
         end
         ST_CALC: begin
            if (ofs_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         mode_ff      <= 1'b0;
         wrap_ff      <= 1'b0;
         sector_ff    <= '0;
         track_ff     <= '0;
         sbm1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         mode_ff      <= mode_in;
         wrap_ff      <= wrap_in;
         sector_ff    <= sector_in;
         track_ff     <= track_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr[2] == REG_SECTOR_BYTES) begin
            sbm1_ff <= csr_pwdata[7:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   // Offset unit
   assign ofs_req.sector     = ofs_sec;
   assign ofs_req.track_head = track_ff;
   assign ofs_req.bytes_m1   = sbm1_ff;

   dbss_offset_unit u_offset (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && need_ofs),
      .ofs_req (ofs_req),
      .done    (ofs_done),
      .offset  (ofs_value)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == REG_SECTOR_BYTES) ?
                        {{(CSR_DATA_W-8){1'b0}}, sbm1_ff} : '0;

endmodule

// File: rtl/dbss_checker.sv
// Port-level checks for the disk buffer sector sequencer, bound to the top.
// Depends on dbss_pkg.
module dbss_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dbss_pkg::rsp_type rsp_payload
);
   import dbss_pkg::*;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // One item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");

   // Both C1 flags move together and the kind is a known code
   a_c1_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.c1_single == rsp_payload.c1_double &&
                    (rsp_payload.transfer_kind == KIND_NONE ||
                     rsp_payload.transfer_kind == KIND_READ ||
                     rsp_payload.transfer_kind == KIND_WRITE))
      else $error("inconsistent C1 flags or transfer kind");

   // Without an interrupt nothing is requested or moved
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.irq_raised |->
         rsp_payload.transfer_kind == KIND_NONE && !rsp_payload.user_request &&
         !rsp_payload.c2_request && !rsp_payload.c1_single &&
         rsp_payload.disk_offset == '0)
      else $error("activity reported without interrupt");

   // A moved sector is a user request and keeps the transfer running
   a_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.transfer_kind != KIND_NONE |->
         rsp_payload.user_request && rsp_payload.busy_res && !rsp_payload.c2_request)
      else $error("sector move without user request or running state");

endmodule

bind disk_buffer_sector_sequencer dbss_checker u_dbss_checker (.*);

// File: sim/disk_buffer_sector_sequencer_test.sv
// Self-checking testbench for disk_buffer_sector_sequencer: directed and random
// start/tick beats, APB writes of the sector size, and a beat-level predictor.
// Depends on dbss_pkg and the sequencer RTL.
module disk_buffer_sector_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dbss_pkg::*;

   localparam int IDLE_PCT     = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [CSR_ADDR_W-1:0] SECTOR_BYTES_ADDR = {REG_SECTOR_BYTES, 2'b00};

   // Predicts each result beat of the sequencer and checks the DUT against it
   class sector_step_board;
      rsp_type     expected_steps[$];
      int unsigned mismatches;
      logic        running;
      logic        read_mode;
      logic        wrap_pending;
      logic [7:0]  cur_sector;
      logic [12:0] track_head;
      logic [7:0]  bytes_m1;

      function new();
         mismatches   = 0;
         running      = 1'b0;
         read_mode    = 1'b0;
         wrap_pending = 1'b0;
         cur_sector   = '0;
         track_head   = '0;
         bytes_m1     = '0;
      endfunction

      function void set_sector_bytes(input logic [7:0] value);
         bytes_m1 = value;
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      // First track of each of the eight zones
      function logic [31:0] first_track(input int zone);
         case (zone)
            0:       return 32'h000;
            1:       return 32'h09E;
            2:       return 32'h13C;
            3:       return 32'h1D1;
            4:       return 32'h266;
            5:       return 32'h2FB;
            6:       return 32'h390;
            default: return 32'h425;
         endcase
      endfunction

      // Disk image offset of each zone's first track, head 1 in the upper half
      function logic [31:0] zone_base(input int idx);
         case (idx)
            0:       return 32'h0000000;
            1:       return 32'h05F15E0;
            2:       return 32'h0B79D00;
            3:       return 32'h10801A0;
            4:       return 32'h1523720;
            5:       return 32'h1963D80;
            6:       return 32'h1D414C0;
            7:       return 32'h20BBCE0;
            8:       return 32'h23196E0;
            9:       return 32'h28A1E00;
            10:      return 32'h2DF5DC0;
            11:      return 32'h3299340;
            12:      return 32'h36D99A0;
            13:      return 32'h3AB70E0;
            14:      return 32'h3E31900;
            default: return 32'h4149200;
         endcase
      endfunction

      // Zoned byte offset, summed in 32 bits, low 27 bits kept
      function logic [OFS_W-1:0] zoned_offset(input logic [7:0] sec);
         logic [31:0] blk;
         logic [31:0] slot;
         logic [31:0] trk;
         logic [31:0] bytes;
         logic [31:0] sum;
         int          zone;
         blk   = (sec >= SLOTS_PER_BLOCK) ? 32'd1 : 32'd0;
         slot  = 32'(sec) - blk * 32'(SLOTS_PER_BLOCK);
         trk   = 32'(track_head[11:0]);
         bytes = 32'(bytes_m1) + 32'd1;
         zone  = 0;
         for (int k = 1; k < 8; k++)
            if (trk >= first_track(k))
               zone++;
         trk = trk - first_track(zone);
         sum = zone_base(zone + (track_head[12] ? 8 : 0))
               + 32'(USER_SLOTS) * bytes * 32'd2 * trk
               + blk * 32'(USER_SLOTS) * bytes + slot * bytes;
         return sum[OFS_W-1:0];
      endfunction

      // Advance the predicted state by one accepted input beat
      function void note_beat(input req_type r);
         rsp_type    e;
         logic [7:0] s;
         logic [7:0] slot;
         logic       blk;
         e = '0;
         if (r.action == ACT_START) begin
            running      = 1'b1;
            read_mode    = r.read_mode;
            wrap_pending = r.block_transfer;
            track_head   = r.track;
            cur_sector   = r.sector;
         end else if (running) begin
            e.irq_raised = 1'b1;
            s    = cur_sector;
            blk  = (s >= SLOTS_PER_BLOCK);
            slot = blk ? s - SLOTS_PER_BLOCK : s;
            if (read_mode) begin
               if (track_head == C1_TRACK) begin
                  e.c1_single = 1'b1;
                  e.c1_double = 1'b1;
               end
               if (slot < USER_SLOTS) begin
                  e.disk_offset   = zoned_offset(s);
                  e.transfer_kind = KIND_READ;
                  e.user_request  = 1'b1;
                  s = s + 8'd1;
               end else if (slot < LAST_C2_SLOT) begin
                  s = s + 8'd1;
               end else if (slot == LAST_C2_SLOT) begin
                  e.c2_request = 1'b1;
                  if (wrap_pending) begin
                     wrap_pending = 1'b0;
                     s = blk ? 8'd0 : SLOTS_PER_BLOCK;
                  end else begin
                     running = 1'b0;
                  end
               end
               // spare slot and sectors past block 1: parked, nothing moves
            end else begin
               if (slot <= USER_SLOTS) begin
                  // slot 0 only raises the request, no sector precedes it
                  if (slot > 0) begin
                     e.disk_offset   = zoned_offset(s - 8'd1);
                     e.transfer_kind = KIND_WRITE;
                  end
                  e.user_request = 1'b1;
               end
               if (slot >= USER_SLOTS) begin
                  if (wrap_pending) begin
                     wrap_pending = 1'b0;
                     s = blk ? 8'd0 : SLOTS_PER_BLOCK;
                  end else if (slot >= WRITE_STOP_SLOT) begin
                     running = 1'b0;
                  end
               end
               s = s + 8'd1;
            end
            cur_sector = s;
         end
         e.busy_res    = running;
         e.next_sector = cur_sector;
         expected_steps.push_back(e);
      endfunction

      function void compare(input string field, input logic [31:0] want,
                            input logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      // Check one accepted result beat against the oldest prediction
      function void check_beat(input rsp_type got);
         rsp_type want;
         if (expected_steps.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = expected_steps.pop_front();
         compare("irq_raised", 32'(want.irq_raised), 32'(got.irq_raised));
         compare("user_request", 32'(want.user_request), 32'(got.user_request));
         compare("c2_request", 32'(want.c2_request), 32'(got.c2_request));
         compare("c1_single", 32'(want.c1_single), 32'(got.c1_single));
         compare("c1_double", 32'(want.c1_double), 32'(got.c1_double));
         compare("transfer_kind", 32'(want.transfer_kind), 32'(got.transfer_kind));
         compare("disk_offset", 32'(want.disk_offset), 32'(got.disk_offset));
         compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
         compare("next_sector", 32'(want.next_sector), 32'(got.next_sector));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sector_step_board board = new();
   bit                    calm = 1'b0;
   bit                    hold_request = 1'b0;
   int                    beats_sent = 0;

   disk_buffer_sector_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one input beat, with a random gap first, and wait for acceptance
   task automatic send_beat(input req_type r);
      while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_beat(r);
      beats_sent++;
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // APB write of the sector size register: setup, then access
   task automatic write_sector_bytes(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SECTOR_BYTES_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.set_sector_bytes(value[7:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic req_type make_tick();
      req_type r;
      r = req_type'($urandom);
      r.action = ACT_TICK;
      return r;
   endfunction

   function automatic req_type make_start(input logic rd, input logic bt,
                                          input logic [12:0] trk, input logic [7:0] sec);
      req_type r;
      r.action         = ACT_START;
      r.read_mode      = rd;
      r.block_transfer = bt;
      r.track          = trk;
      r.sector         = sec;
      return r;
   endfunction

   // Random start: tracks biased to zone edges and the copy-protected track,
   // sectors biased toward block ends so runs reach the C2 slots and wrap
   function automatic req_type random_start();
      req_type     r;
      int          pick;
      logic [11:0] edge_trk;
      r = req_type'($urandom);
      r.action = ACT_START;
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         r.track = C1_TRACK;
      end else if (pick <= 2) begin
         case ($urandom_range(7, 0))
            0:       edge_trk = 12'h09E;
            1:       edge_trk = 12'h13C;
            2:       edge_trk = 12'h1D1;
            3:       edge_trk = 12'h266;
            4:       edge_trk = 12'h2FB;
            5:       edge_trk = 12'h390;
            6:       edge_trk = 12'h425;
            default: edge_trk = 12'hFFF;
         endcase
         r.track[11:0] = edge_trk - 12'($urandom_range(1, 0));
      end
      pick = $urandom_range(9, 0);
      if (pick == 0)
         r.sector = 8'($urandom_range(255, 180));
      else if (pick <= 4)
         r.sector = 8'(($urandom_range(1, 0) ? 90 : 0) + $urandom_range(89, 75));
      else
         r.sector = 8'($urandom_range(179, 0));
      return r;
   endfunction

   // One start followed by a run of ticks: mostly to the end of the
   // transfer and a little past, sometimes cut short by the next start
   task automatic run_transfer();
      req_type s;
      int      ticks;
      s = random_start();
      send_beat(s);
      if (s.sector >= 2 * SLOTS_PER_BLOCK)
         ticks = $urandom_range(4, 1);
      else if ($urandom_range(2, 0) == 0)
         ticks = $urandom_range(30, 0);
      else
         ticks = 90 - (int'(s.sector) % 90) + (s.block_transfer ? 90 : 0)
                 + $urandom_range(2, 0);
      repeat (ticks) send_beat(make_tick());
   endtask

   task automatic run_phase(input int beats, input bit quiet);
      int target;
      target = beats_sent + beats;
      calm = quiet;
      while (beats_sent < target)
         run_transfer();
   endtask

   task automatic directed_checks();
      // tick before any start: interrupt lowered
      send_beat(make_tick());
      // read on the copy-protected track through the C2 slots, wrap to block 1
      send_beat(make_start(1'b1, 1'b1, 13'd6, 8'd84));
      repeat (6) send_beat(make_tick());
      // write on the last track of head 1; slot 0 writes no sector
      send_beat(make_start(1'b0, 1'b0, 13'h1FFF, 8'd0));
      repeat (2) send_beat(make_tick());
      // write past the last user slot of block 1 wraps into block 0
      send_beat(make_start(1'b0, 1'b1, 13'h1425, 8'd175));
      repeat (2) send_beat(make_tick());
      // read beyond the last sector parks the sequencer
      send_beat(make_start(1'b1, 1'b0, 13'h009E, 8'd180));
      repeat (2) send_beat(make_tick());
      // read at the spare slot of block 0 parks too
      send_beat(make_start(1'b1, 1'b0, 13'h0FFF, 8'd89));
      send_beat(make_tick());
      // write from the top sector: stops and the counter wraps to zero
      send_beat(make_start(1'b0, 1'b0, 13'h0000, 8'd255));
      repeat (2) send_beat(make_tick());
      // write starting at the stop slot ends at once
      send_beat(make_start(1'b0, 1'b0, 13'h1006, 8'd86));
      send_beat(make_tick());
   endtask

   // Result side: check accepted beats, random stalls and one long hold-off
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready)
            board.check_beat(rsp_payload);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: too long without any beat or register access ends the run
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Main sequence: reset, directed beats, then random phases per sector size
   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      drain_results();

      // largest sector, no idling on either side
      write_sector_bytes(32'($urandom) | 32'h0000_00FF);
      run_phase(330, 1'b1);
      drain_results();

      // smallest sector; receiver holds off while beats keep coming
      write_sector_bytes(32'($urandom) & 32'hFFFF_FF00);
      run_phase(50, 1'b0);
      hold_request = 1'b1;
      run_phase(280, 1'b0);
      drain_results();

      // random size; sender pauses until the pipe is empty
      write_sector_bytes(32'($urandom));
      run_phase(150, 1'b0);
      drain_results();
      run_phase(180, 1'b0);
      drain_results();

      write_sector_bytes(32'h0000_0001);
      run_phase(330, 1'b0);
      drain_results();

      write_sector_bytes(32'($urandom));
      run_phase(330, 1'b0);
      drain_results();

      write_sector_bytes(32'h0000_00FF);
      run_phase(300, 1'b0);
      drain_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
